FILE: rtl/lotsch_pkg.sv
package lotsch_pkg;

    // field widths
    localparam int TICKET_W = 12;
    localparam int TIME_W   = 16;
    localparam int TIX_IN_W = 8;
    localparam int RAND_W   = 16;
    localparam int INDEX_W  = 4;

    // largest ticket total a load may reach
    localparam logic [TICKET_W-1:0] TICKET_LIMIT  = 12'd4095;
    // quantum after reset
    localparam logic [TIME_W-1:0]   QUANTUM_RESET = 16'd20;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // one client entry as held in the table memory
    typedef struct packed {
        logic [TICKET_W-1:0] range_start;
        logic [TICKET_W-1:0] range_end;
        logic [TIME_W-1:0]   remaining;
        logic                finished;
    } entry_t;

endpackage

FILE: rtl/lotsch_ram.sv
module lotsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lottery_scheduler.sv
// lottery scheduler: a table of clients, each owning a contiguous ticket range
// and a remaining service time.
// input channel (in_valid / in_ready): kind 0 loads a client with burst_time
// and tickets, kind 1 draws with random_value. one result word per input word.
// output channel (out_valid / out_ready): accepted, winner_found, winner_index,
// winner_finished, all_done and drawn_ticket.
// quantum is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, the block itself does not enforce this.
// one item is worked at a time. a load, or a draw on an empty ticket total,
// goes to ST_RESULT, then into the output register; the next word can be
// taken once the sequencer is back in ST_IDLE. a draw runs a one-bit-per-cycle
// remainder unit over random_value, then scans the table memory one entry per
// cycle up to the first unfinished entry holding the ticket, or its last entry.
// the next word is taken once the previous result sits in the output register,
// so a stalled receiver holds at most one result and one item in progress.
// reset empties the table (count, ticket total) and sets quantum to 20; the
// table memory itself is not cleared, only entries below the count are read.
module lottery_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] burst_time,
    input  logic [7:0]  tickets,
    input  logic [15:0] random_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic        winner_found,
    output logic [3:0]  winner_index,
    output logic        winner_finished,
    output logic        all_done,
    output logic [11:0] drawn_ticket,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int TW  = lotsch_pkg::TICKET_W;
    localparam int MW  = lotsch_pkg::TIME_W;
    localparam int RW  = lotsch_pkg::RAND_W;
    localparam int DCW = $clog2(RW);
    localparam int EW  = $bits(lotsch_pkg::entry_t);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIV    = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    // control state
    logic [1:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [TW-1:0]  total_reg, total_next;
    logic [CW-1:0]  unfinished_reg, unfinished_next;
    logic [MW-1:0]  quantum_reg, quantum_next;
    logic           out_valid_reg, out_valid_next;
    logic           chk_valid_reg, chk_valid_next;
    logic [CW-1:0]  scan_idx_reg, scan_idx_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;

    // working payload
    logic [RW-1:0]  dividend_reg, dividend_next;
    logic [TW-1:0]  rem_reg, rem_next;
    logic [IW-1:0]  chk_idx_reg, chk_idx_next;
    logic           res_acc_reg, res_acc_next;
    logic           res_found_reg, res_found_next;
    logic [IW-1:0]  res_idx_reg, res_idx_next;
    logic           res_fin_reg, res_fin_next;
    logic [TW-1:0]  res_ticket_reg, res_ticket_next;

    // output word
    logic           out_acc_reg, out_acc_next;
    logic           out_found_reg, out_found_next;
    logic [3:0]     out_idx_reg, out_idx_next;
    logic           out_fin_reg, out_fin_next;
    logic           out_done_reg, out_done_next;
    logic [TW-1:0]  out_ticket_reg, out_ticket_next;

    // table memory ports
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    lotsch_pkg::entry_t   ram_wentry;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    lotsch_pkg::entry_t   rd_entry;

    // datapath helpers
    logic [TW:0]    load_sum;
    logic           load_ok;
    logic [TW:0]    rem_shift;
    logic           scan_issue;
    logic           scan_match;
    logic           scan_last;
    logic           out_free;

    lotsch_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wentry),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = lotsch_pkg::entry_t'(ram_rdata);

    // load admission
    assign load_sum = {1'b0, total_reg} + (TW + 1)'(tickets);
    assign load_ok  = (count_reg < CW'(MAX_PROCS))
                   && (load_sum <= {1'b0, lotsch_pkg::TICKET_LIMIT});

    // remainder step: one dividend bit per cycle
    assign rem_shift = {rem_reg, dividend_reg[RW-1]};

    // table scan, one read issued per cycle, checked in the cycle after
    assign scan_issue = (scan_idx_reg < count_reg);
    assign scan_match = chk_valid_reg && !rd_entry.finished
                     && (rd_entry.range_start <= rem_reg)
                     && (rem_reg < rd_entry.range_end);
    assign scan_last  = chk_valid_reg && ((CW'(chk_idx_reg) + CW'(1)) == count_reg);

    assign out_free = !out_valid_reg || out_ready;

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        unfinished_next = unfinished_reg;
        quantum_next    = cfg_wr_en ? cfg_wr_data : quantum_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        chk_valid_next  = 1'b0;
        scan_idx_next   = scan_idx_reg;
        div_cnt_next    = div_cnt_reg;

        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        chk_idx_next    = chk_idx_reg;
        res_acc_next    = res_acc_reg;
        res_found_next  = res_found_reg;
        res_idx_next    = res_idx_reg;
        res_fin_next    = res_fin_reg;
        res_ticket_next = res_ticket_reg;

        out_acc_next    = out_acc_reg;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;
        out_fin_next    = out_fin_reg;
        out_done_next   = out_done_reg;
        out_ticket_next = out_ticket_reg;

        ram_we                 = 1'b0;
        ram_waddr              = count_reg[IW-1:0];
        ram_wentry.range_start = total_reg;
        ram_wentry.range_end   = load_sum[TW-1:0];
        ram_wentry.remaining   = burst_time;
        ram_wentry.finished    = 1'b0;
        ram_raddr              = scan_idx_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_acc_next    = 1'b0;
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_fin_next    = 1'b0;
                    res_ticket_next = '0;
                    if (kind == lotsch_pkg::KIND_LOAD)
                    begin
                        // append the client at the end of the table
                        if (load_ok)
                        begin
                            ram_we          = 1'b1;
                            count_next      = count_reg + CW'(1);
                            total_next      = load_sum[TW-1:0];
                            unfinished_next = unfinished_reg + CW'(1);
                            res_acc_next    = 1'b1;
                            res_idx_next    = count_reg[IW-1:0];
                        end
                        state_next = ST_RESULT;
                    end
                    else if (total_reg == '0)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        dividend_next = random_value;
                        rem_next      = '0;
                        div_cnt_next  = DCW'(RW - 1);
                        state_next    = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // restoring remainder, the partial value stays below the total
                if (rem_shift >= {1'b0, total_reg})
                begin
                    rem_next = TW'(rem_shift - {1'b0, total_reg});
                end
                else
                begin
                    rem_next = rem_shift[TW-1:0];
                end
                dividend_next = {dividend_reg[RW-2:0], 1'b0};
                div_cnt_next  = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == '0)
                begin
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                res_acc_next    = 1'b1;
                res_ticket_next = rem_reg;
                if (scan_match)
                begin
                    // winner: take the quantum off and write the entry back
                    ram_we     = 1'b1;
                    ram_waddr  = chk_idx_reg;
                    ram_wentry = rd_entry;
                    res_found_next = 1'b1;
                    res_idx_next   = chk_idx_reg;
                    if (rd_entry.remaining <= quantum_reg)
                    begin
                        ram_wentry.remaining = '0;
                        ram_wentry.finished  = 1'b1;
                        res_fin_next         = 1'b1;
                        unfinished_next      = unfinished_reg - CW'(1);
                    end
                    else
                    begin
                        ram_wentry.remaining = rd_entry.remaining - quantum_reg;
                    end
                    state_next = ST_RESULT;
                end
                else if (scan_last)
                begin
                    state_next = ST_RESULT;
                end
                else if (scan_issue)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg[IW-1:0];
                    scan_idx_next  = scan_idx_reg + CW'(1);
                end
            end

            ST_RESULT:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_acc_next    = res_acc_reg;
                    out_found_next  = res_found_reg;
                    out_idx_next    = 4'(res_idx_reg);
                    out_fin_next    = res_fin_reg;
                    out_done_next   = (unfinished_reg == '0);
                    out_ticket_next = res_ticket_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            total_reg      <= '0;
            unfinished_reg <= '0;
            quantum_reg    <= lotsch_pkg::QUANTUM_RESET;
            out_valid_reg  <= 1'b0;
            chk_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            unfinished_reg <= unfinished_next;
            quantum_reg    <= quantum_next;
            out_valid_reg  <= out_valid_next;
            chk_valid_reg  <= chk_valid_next;
            scan_idx_reg   <= scan_idx_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dividend_reg   <= dividend_next;
        rem_reg        <= rem_next;
        chk_idx_reg    <= chk_idx_next;
        res_acc_reg    <= res_acc_next;
        res_found_reg  <= res_found_next;
        res_idx_reg    <= res_idx_next;
        res_fin_reg    <= res_fin_next;
        res_ticket_reg <= res_ticket_next;
        out_acc_reg    <= out_acc_next;
        out_found_reg  <= out_found_next;
        out_idx_reg    <= out_idx_next;
        out_fin_reg    <= out_fin_next;
        out_done_reg   <= out_done_next;
        out_ticket_reg <= out_ticket_next;
    end

    // ports
    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign accepted        = out_acc_reg;
    assign winner_found    = out_found_reg;
    assign winner_index    = out_idx_reg;
    assign winner_finished = out_fin_reg;
    assign all_done        = out_done_reg;
    assign drawn_ticket    = out_ticket_reg;

    // unfinished clients never outnumber loaded ones
    assert property (@(posedge clk) disable iff (!rst_n)
        unfinished_reg <= count_reg)
        else $error("unfinished count above client count");

    // table never grows past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_PROCS))
        else $error("client count above table depth");

    // the reduced ticket lies below the ticket total during the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> rem_reg < total_reg)
        else $error("drawn ticket not below ticket total");

    // a finishing winner is a winner of an accepted draw
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fin_reg |-> out_found_reg && out_acc_reg)
        else $error("finished flag without accepted winner");

    // a scan never issues a read beyond the loaded clients
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> scan_idx_reg <= count_reg)
        else $error("scan index beyond client count");

endmodule
